/* rtl/sparse_row_diagonal_inserter_unit_macros.svh */
// Assertion macros for the sparse row diagonal inserter.
// Used by the port checker; no other dependencies.
`ifndef SPARSE_ROW_DIAGONAL_INSERTER_UNIT_MACROS_SVH
`define SPARSE_ROW_DIAGONAL_INSERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRDI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SRDI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/srdi_pkg.sv */
// Shared types and constants for the sparse row diagonal inserter.
// No dependencies; used by the interfaces and all modules.
package srdi_pkg;

   // Row buffer depth and the widths that follow from it
   localparam int MAX_ROW_ENTRIES = 32;
   localparam int ADDR_W = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;
   localparam int FILL_W = $clog2(MAX_ROW_ENTRIES + 1);

   // Field widths
   localparam int COL_W = 31;
   localparam int VAL_W = 64;
   localparam int POS_W = 32;

   // Reset value of the column count register
   localparam logic [COL_W-1:0] COLUMN_COUNT_RESET = COL_W'(1);

   // One buffered entry
   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
   } srdi_entry_type;

   // Row sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW,
      ST_TAIL
   } srdi_state_type;

endpackage

/* rtl/srdi_if.sv */
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on srdi_pkg for field widths.
interface srdi_req_if;
   logic                          valid;
   logic                          ready;
   logic                          start_matrix;
   logic                          no_entry;
   logic [srdi_pkg::COL_W-1:0]    entry_column;
   logic [srdi_pkg::VAL_W-1:0]    entry_value;
   logic                          row_end;

   modport source (output valid, start_matrix, no_entry, entry_column, entry_value, row_end,
                   input ready);
   modport sink   (input valid, start_matrix, no_entry, entry_column, entry_value, row_end,
                   output ready);
endinterface

interface srdi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srdi_pkg::COL_W-1:0]    out_row;
   logic [srdi_pkg::COL_W-1:0]    out_column;
   logic [srdi_pkg::VAL_W-1:0]    out_value;
   logic [srdi_pkg::POS_W-1:0]    out_position;
   logic                          was_inserted;
   logic                          last_of_row;
   logic                          row_overflow;

   modport source (output valid, out_row, out_column, out_value, out_position,
                   was_inserted, last_of_row, row_overflow, input ready);
   modport sink   (input valid, out_row, out_column, out_value, out_position,
                   was_inserted, last_of_row, row_overflow, output ready);
endinterface

interface srdi_csr_if;
   logic                          valid;
   logic                          ready;
   logic [srdi_pkg::COL_W-1:0]    data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/srdi_row_mem.sv */
// Row buffer: one write port, one read port, registered read data.
// Depends on srdi_pkg for depth and entry type.
module srdi_row_mem (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [srdi_pkg::ADDR_W-1:0]       wr_addr,
   input  srdi_pkg::srdi_entry_type          wr_data,
   input  logic                              rd_en,
   input  logic [srdi_pkg::ADDR_W-1:0]       rd_addr,
   output srdi_pkg::srdi_entry_type          rd_data
);

   srdi_pkg::srdi_entry_type mem [srdi_pkg::MAX_ROW_ENTRIES];
   srdi_pkg::srdi_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sparse_row_diagonal_inserter_unit.sv */
// Diagonal inserter: buffers a row, then emits it with a missing zero diagonal added.
// Depends on srdi_pkg, the srdi interfaces and srdi_row_mem.
// Items are taken one per cycle while idle; at a row end the input is held while the
// row is read and sent, one result per cycle unless stalled, plus any added diagonal;
// an empty row holds it for its diagonal, added only for rows below the column count.
// Synchronous reset clears counters, flags and the sequencer; the buffer is not cleared.
module sparse_row_diagonal_inserter_unit (
   input  logic         clock,
   input  logic         reset,
   srdi_req_if.sink     req_if,
   srdi_rsp_if.source   rsp_if,
   srdi_csr_if.sink     csr_if
);

   localparam logic [srdi_pkg::FILL_W-1:0] FILL_MAX =
      srdi_pkg::FILL_W'(srdi_pkg::MAX_ROW_ENTRIES);

   // Control and row state
   srdi_pkg::srdi_state_type          state_ff, state_in;
   logic [srdi_pkg::FILL_W-1:0]       fill_ff, fill_in;
   logic                              diag_ff, diag_in;
   logic                              ovf_ff, ovf_in;
   logic [srdi_pkg::COL_W-1:0]        row_ff, row_in;
   logic [srdi_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic                              need_ff, need_in;
   logic                              ins_ff, ins_in;
   logic [srdi_pkg::FILL_W-1:0]       idx_ff, idx_in;
   logic [srdi_pkg::COL_W-1:0]        ccount_ff;

   // Output register
   logic                              rsp_valid_ff;
   logic [srdi_pkg::COL_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic [srdi_pkg::VAL_W-1:0]        rsp_val_ff;
   logic [srdi_pkg::POS_W-1:0]        rsp_pos_ff;
   logic                              rsp_ins_ff, rsp_last_ff, rsp_ovf_ff;

   // Accept-side terms
   logic                              accept;
   logic                              row_done;
   logic [srdi_pkg::COL_W-1:0]        eff_row;
   logic [srdi_pkg::POS_W-1:0]        eff_pos;
   logic [srdi_pkg::FILL_W-1:0]       eff_fill, fill_new;
   logic                              eff_diag, eff_ovf;
   logic                              wr_en;
   logic                              diag_new, ovf_new, need_new;

   // Emit-side terms
   srdi_pkg::srdi_entry_type          wr_data, rd_data;
   logic                              rd_en;
   logic [srdi_pkg::ADDR_W-1:0]       rd_addr;
   logic [srdi_pkg::FILL_W-1:0]       idx_plus;
   logic                              out_free;
   logic                              pend_diag;
   logic                              last_entry;
   logic                              emit_entry, emit_diag, emit_tail;
   logic                              load;
   logic [srdi_pkg::COL_W-1:0]        load_col;
   logic [srdi_pkg::VAL_W-1:0]        load_val;
   logic                              load_ins, load_last;

   // Row buffer
   srdi_row_mem u_row_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eff_fill[srdi_pkg::ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration and input handshakes
   assign csr_if.ready = 1'b1;
   assign req_if.ready = (state_ff == srdi_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign row_done     = req_if.row_end || req_if.no_entry;

   // Apply a matrix restart before the item is taken
   always_comb begin
      eff_row  = req_if.start_matrix ? '0 : row_ff;
      eff_pos  = req_if.start_matrix ? '0 : pos_ff;
      eff_fill = req_if.start_matrix ? '0 : fill_ff;
      eff_diag = req_if.start_matrix ? 1'b0 : diag_ff;
      eff_ovf  = req_if.start_matrix ? 1'b0 : ovf_ff;
      wr_en    = accept && !req_if.no_entry && (eff_fill < FILL_MAX);
      fill_new = eff_fill + srdi_pkg::FILL_W'(wr_en);
      diag_new = eff_diag || (wr_en && (req_if.entry_column == eff_row));
      ovf_new  = eff_ovf || (!req_if.no_entry && (eff_fill >= FILL_MAX));
      need_new = (eff_row < ccount_ff) && !diag_new;
      wr_data.column = req_if.entry_column;
      wr_data.value  = req_if.entry_value;
   end

   // Emit decisions
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign pend_diag  = need_ff && !ins_ff;
   assign idx_plus   = idx_ff + srdi_pkg::FILL_W'(1);
   assign last_entry = (idx_plus == fill_ff);

   always_comb begin
      emit_diag  = 1'b0;
      emit_entry = 1'b0;
      emit_tail  = 1'b0;
      if (state_ff == srdi_pkg::ST_SHOW && out_free) begin
         if (pend_diag && (rd_data.column > row_ff)) begin
            emit_diag = 1'b1;
         end else begin
            emit_entry = 1'b1;
         end
      end
      if (state_ff == srdi_pkg::ST_TAIL && out_free) begin
         emit_tail = 1'b1;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srdi_pkg::ST_IDLE: begin
            if (accept && row_done) begin
               if (fill_new != '0) begin
                  state_in = srdi_pkg::ST_READ;
               end else if (need_new) begin
                  state_in = srdi_pkg::ST_TAIL;
               end
            end
         end
         srdi_pkg::ST_READ: begin
            state_in = srdi_pkg::ST_SHOW;
         end
         srdi_pkg::ST_SHOW: begin
            if (emit_entry && last_entry) begin
               state_in = pend_diag ? srdi_pkg::ST_TAIL : srdi_pkg::ST_IDLE;
            end
         end
         srdi_pkg::ST_TAIL: begin
            if (out_free) begin
               state_in = srdi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srdi_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer and row state updates
   always_comb begin
      fill_in = fill_ff;
      diag_in = diag_ff;
      ovf_in  = ovf_ff;
      row_in  = row_ff;
      pos_in  = pos_ff;
      need_in = need_ff;
      ins_in  = ins_ff;
      idx_in  = idx_ff;
      rd_en   = 1'b0;
      rd_addr = idx_ff[srdi_pkg::ADDR_W-1:0];
      load      = emit_diag || emit_entry || emit_tail;
      load_col  = row_ff;
      load_val  = '0;
      load_ins  = 1'b1;
      load_last = 1'b0;
      unique case (state_ff)
         srdi_pkg::ST_IDLE: begin
            // Take an item; close the row at once if it yields no result
            if (accept) begin
               fill_in = fill_new;
               diag_in = diag_new;
               ovf_in  = ovf_new;
               row_in  = eff_row;
               pos_in  = eff_pos;
               need_in = need_new;
               ins_in  = 1'b0;
               idx_in  = '0;
               if (row_done && (fill_new == '0) && !need_new) begin
                  row_in  = eff_row + srdi_pkg::COL_W'(1);
                  fill_in = '0;
                  diag_in = 1'b0;
                  ovf_in  = 1'b0;
               end
            end
         end
         srdi_pkg::ST_READ: begin
            // Fetch the first buffered entry
            rd_en = 1'b1;
         end
         srdi_pkg::ST_SHOW: begin
            if (emit_diag) begin
               ins_in = 1'b1;
            end
            if (emit_entry) begin
               load_col  = rd_data.column;
               load_val  = rd_data.value;
               load_ins  = 1'b0;
               load_last = last_entry && !pend_diag;
               idx_in    = idx_plus;
               if (!last_entry) begin
                  // Fetch the next entry while this one moves out
                  rd_en   = 1'b1;
                  rd_addr = idx_plus[srdi_pkg::ADDR_W-1:0];
               end else if (!pend_diag) begin
                  row_in  = row_ff + srdi_pkg::COL_W'(1);
                  fill_in = '0;
                  diag_in = 1'b0;
                  ovf_in  = 1'b0;
               end
            end
         end
         srdi_pkg::ST_TAIL: begin
            // Diagonal at the end of the row
            load_last = 1'b1;
            if (emit_tail) begin
               ins_in  = 1'b1;
               row_in  = row_ff + srdi_pkg::COL_W'(1);
               fill_in = '0;
               diag_in = 1'b0;
               ovf_in  = 1'b0;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      if (load) begin
         pos_in = pos_ff + srdi_pkg::POS_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srdi_pkg::ST_IDLE;
         fill_ff      <= '0;
         diag_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         row_ff       <= '0;
         pos_ff       <= '0;
         need_ff      <= 1'b0;
         ins_ff       <= 1'b0;
         idx_ff       <= '0;
         ccount_ff    <= srdi_pkg::COLUMN_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         diag_ff  <= diag_in;
         ovf_ff   <= ovf_in;
         row_ff   <= row_in;
         pos_ff   <= pos_in;
         need_ff  <= need_in;
         ins_ff   <= ins_in;
         idx_ff   <= idx_in;
         if (csr_if.valid && csr_if.ready) begin
            ccount_ff <= csr_if.data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload; hold while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= load_col;
         rsp_val_ff  <= load_val;
         rsp_pos_ff  <= pos_ff;
         rsp_ins_ff  <= load_ins;
         rsp_last_ff <= load_last;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_row      = rsp_row_ff;
   assign rsp_if.out_column   = rsp_col_ff;
   assign rsp_if.out_value    = rsp_val_ff;
   assign rsp_if.out_position = rsp_pos_ff;
   assign rsp_if.was_inserted = rsp_ins_ff;
   assign rsp_if.last_of_row  = rsp_last_ff;
   assign rsp_if.row_overflow = rsp_ovf_ff;

endmodule

/* rtl/srdi_checker.sv */
// Port checker for the sparse row diagonal inserter, bound to the top level.
// Depends on srdi_pkg and sparse_row_diagonal_inserter_unit_macros.svh.
`include "sparse_row_diagonal_inserter_unit_macros.svh"

module srdi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [srdi_pkg::COL_W-1:0]    rsp_row,
   input logic [srdi_pkg::COL_W-1:0]    rsp_column,
   input logic [srdi_pkg::VAL_W-1:0]    rsp_value,
   input logic [srdi_pkg::POS_W-1:0]    rsp_position,
   input logic                          rsp_inserted,
   input logic                          rsp_last
);

   // Stalled result stays offered
   `SRDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   // Stalled result keeps its position
   `SRDI_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_position), "result position changed while stalled")
   // Added diagonal sits on the diagonal with zero value
   `SRDI_ASSERT_NOW(a_diag_shape, clock, reset, rsp_valid && rsp_inserted, (rsp_column == rsp_row) && (rsp_value == '0), "inserted entry is not a zero diagonal")
   // No new item while a row is still being sent out
   `SRDI_ASSERT_NOW(a_row_busy, clock, reset, rsp_valid && !rsp_last, !req_ready, "input taken in the middle of a row")

endmodule

bind sparse_row_diagonal_inserter_unit srdi_checker u_srdi_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_row      (rsp_if.out_row),
   .rsp_column   (rsp_if.out_column),
   .rsp_value    (rsp_if.out_value),
   .rsp_position (rsp_if.out_position),
   .rsp_inserted (rsp_if.was_inserted),
   .rsp_last     (rsp_if.last_of_row)
);

/* test/srdi_row_checker.sv */
// Checker for the sparse row diagonal inserter: predicts every result item and compares.
// Depends on srdi_pkg and the srdi channel interfaces; watches the channels only.
`timescale 1ns / 100ps

module srdi_row_checker
   import srdi_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   srdi_req_if    req,
   srdi_rsp_if    rsp,
   srdi_csr_if    csr,
   output int     mismatches,
   output int     awaited
);

   // One predicted result item
   typedef struct packed {
      logic [COL_W-1:0] row;
      logic [COL_W-1:0] column;
      logic [VAL_W-1:0] value;
      logic [POS_W-1:0] position;
      logic             inserted;
      logic             last;
      logic             overflow;
   } row_entry_t;

   // Predicted block state
   logic [COL_W-1:0] column_limit;
   logic [COL_W-1:0] row_cols [MAX_ROW_ENTRIES];
   logic [VAL_W-1:0] row_vals [MAX_ROW_ENTRIES];
   int               row_fill;
   logic             diag_present;
   logic [COL_W-1:0] current_row;
   logic [POS_W-1:0] next_position;
   logic             overflow_seen;

   row_entry_t       pending_entries [$];

   // Count a mismatch and print one line for it
   task automatic report_mismatch(string what);
      mismatches = mismatches + 1;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [POS_W-1:0] position,
                              logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s at position %0d: got %h, expected %h",
                                   name, position, got, want));
      end
   endtask

   function automatic void clear_row();
      row_fill = 0;
      diag_present = 1'b0;
      overflow_seen = 1'b0;
   endfunction

   // Append one emitted entry and advance the output position
   function automatic void queue_entry(logic [COL_W-1:0] column, logic [VAL_W-1:0] value,
                                       logic inserted);
      row_entry_t e;
      e.row = current_row;
      e.column = column;
      e.value = value;
      e.position = next_position;
      e.inserted = inserted;
      e.last = 1'b0;
      e.overflow = overflow_seen;
      pending_entries.push_back(e);
      next_position = next_position + 1'b1;
   endfunction

   // Buffer one input item; at a row end, emit the row with any missing diagonal
   function automatic void predict_row_output(logic start, logic none,
                                              logic [COL_W-1:0] column,
                                              logic [VAL_W-1:0] value, logic fin);
      int   emitted;
      logic need_diag;
      logic placed;
      emitted = 0;
      placed = 1'b0;
      if (start) begin
         current_row = '0;
         next_position = '0;
         clear_row();
      end
      if (!none) begin
         if (row_fill < MAX_ROW_ENTRIES) begin
            row_cols[row_fill] = column;
            row_vals[row_fill] = value;
            row_fill = row_fill + 1;
            if (column == current_row) begin
               diag_present = 1'b1;
            end
         end else begin
            overflow_seen = 1'b1;
         end
      end
      if (fin || none) begin
         need_diag = (current_row < column_limit) && !diag_present;
         for (int i = 0; i < row_fill; i++) begin
            if (need_diag && !placed && row_cols[i] > current_row) begin
               queue_entry(current_row, '0, 1'b1);
               placed = 1'b1;
               emitted = emitted + 1;
            end
            queue_entry(row_cols[i], row_vals[i], 1'b0);
            emitted = emitted + 1;
         end
         if (need_diag && !placed) begin
            queue_entry(current_row, '0, 1'b1);
            emitted = emitted + 1;
         end
         if (emitted > 0) begin
            pending_entries[pending_entries.size() - 1].last = 1'b1;
         end
         current_row = current_row + 1'b1;
         clear_row();
      end
   endfunction

   // Compare one accepted result item with the oldest prediction
   task automatic compare_result();
      row_entry_t want;
      if (pending_entries.size() == 0) begin
         report_mismatch($sformatf("result item with nothing expected, position %0d",
                                   rsp.out_position));
      end else begin
         want = pending_entries.pop_front();
         check_field("out_row", want.position, VAL_W'(rsp.out_row), VAL_W'(want.row));
         check_field("out_column", want.position, VAL_W'(rsp.out_column),
                     VAL_W'(want.column));
         check_field("out_value", want.position, rsp.out_value, want.value);
         check_field("out_position", want.position, VAL_W'(rsp.out_position),
                     VAL_W'(want.position));
         check_field("was_inserted", want.position, VAL_W'(rsp.was_inserted),
                     VAL_W'(want.inserted));
         check_field("last_of_row", want.position, VAL_W'(rsp.last_of_row),
                     VAL_W'(want.last));
         check_field("row_overflow", want.position, VAL_W'(rsp.row_overflow),
                     VAL_W'(want.overflow));
      end
   endtask

   // Track register writes, predict on accepted inputs, check accepted results
   always @(posedge clock) begin
      if (reset) begin
         column_limit = COLUMN_COUNT_RESET;
         current_row = '0;
         next_position = '0;
         clear_row();
         pending_entries.delete();
         mismatches = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            column_limit = csr.data;
         end
         if (req.valid && req.ready) begin
            predict_row_output(req.start_matrix, req.no_entry, req.entry_column,
                               req.entry_value, req.row_end);
         end
         if (rsp.valid && rsp.ready) begin
            compare_result();
         end
      end
      awaited <= pending_entries.size();
   end

endmodule

/* test/testbench.sv */
// Top of the diagonal inserter test: clock, reset, stimulus, idling and the verdict.
// Depends on srdi_pkg, the srdi interfaces, the unit under test and srdi_row_checker.
`timescale 1ns / 100ps

module testbench;
   import srdi_pkg::*;

   localparam int RUN_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        take_result = 1'b0;
   int          send_idle_pct = 36;
   int          recv_idle_pct = 83;
   int unsigned cycle_count = 0;
   int          mismatch_count;
   int          results_awaited;

   // Stimulus-side view of the row being sent, used to aim columns at the diagonal
   logic [COL_W-1:0] row_index = '0;
   int               items_sent = 0;
   logic             restart_pending = 1'b0;

   srdi_req_if req_ch ();
   srdi_rsp_if rsp_ch ();
   srdi_csr_if csr_ch ();

   assign rsp_ch.ready = take_result;

   sparse_row_diagonal_inserter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   srdi_row_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .mismatches (mismatch_count),
      .awaited    (results_awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      take_result <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [VAL_W-1:0] random_value();
      return {$urandom, $urandom};
   endfunction

   // Often near the diagonal, otherwise small, anywhere or at the extremes
   function automatic logic [COL_W-1:0] pick_column(logic [COL_W-1:0] row);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 45) begin
         return row + COL_W'($urandom_range(6)) - COL_W'(3);
      end else if (roll < 65) begin
         return COL_W'($urandom_range(40));
      end else if (roll < 85) begin
         return COL_W'($urandom);
      end else if (roll < 93) begin
         return '0;
      end
      return '1;
   endfunction

   // Send one item after a random gap; return at the edge that accepts it
   task automatic send_item(logic start, logic none, logic [COL_W-1:0] column,
                            logic [VAL_W-1:0] value, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.start_matrix <= start;
      req_ch.no_entry <= none;
      req_ch.entry_column <= column;
      req_ch.entry_value <= value;
      req_ch.row_end <= fin;
      do @(posedge clock); while (!req_ch.ready);
      if (start) begin
         row_index = '0;
      end
      if (none || fin) begin
         row_index = row_index + 1'b1;
      end
      items_sent = items_sent + 1;
   endtask

   // Hold the input until every expected result has come, then let the block settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      // let the count of awaited results take in the last accepted item
      @(posedge clock);
      while (results_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_column_count(logic [COL_W-1:0] count);
      drain_results();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= count;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // One row: mostly well formed, sometimes ended by a marker or abandoned by a restart
   task automatic send_random_row();
      int unsigned roll;
      int unsigned len;
      logic        restart;
      logic        by_marker;
      logic        broken;
      logic [COL_W-1:0] column;
      roll = $urandom_range(99);
      if (roll < 25) begin
         len = 0;
      end else if (roll < 88) begin
         len = $urandom_range(5, 1);
      end else if (roll < 96) begin
         len = $urandom_range(20, 6);
      end else begin
         len = $urandom_range(36, 31);
      end
      restart = restart_pending || ($urandom_range(99) < 10);
      restart_pending = 1'b0;
      by_marker = ($urandom_range(99) < 15);
      broken = (len > 0) && ($urandom_range(99) < 5);
      if (restart) begin
         row_index = '0;
      end
      if (len == 0) begin
         send_item(restart, 1'b1, COL_W'($urandom), random_value(), 1'($urandom));
      end else begin
         for (int unsigned k = 0; k < len; k++) begin
            // let a dropped entry sometimes be the diagonal
            if (k >= MAX_ROW_ENTRIES && $urandom_range(1) == 1) begin
               column = row_index;
            end else begin
               column = pick_column(row_index);
            end
            send_item(restart && k == 0, 1'b0, column, random_value(),
                      (k == len - 1) && !by_marker && !broken);
         end
         if (broken) begin
            restart_pending = 1'b1;
         end else if (by_marker) begin
            send_item(1'b0, 1'b1, COL_W'($urandom), random_value(), 1'($urandom));
         end
      end
   endtask

   task automatic send_random_rows(int goal);
      int first;
      first = items_sent;
      while (items_sent - first < goal) begin
         send_random_row();
      end
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.start_matrix <= 1'b0;
      req_ch.no_entry <= 1'b0;
      req_ch.entry_column <= '0;
      req_ch.entry_value <= '0;
      req_ch.row_end <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows with six columns
      write_column_count(COL_W'(6));
      // row 0 holds its own diagonal
      send_item(1'b1, 1'b0, COL_W'(0), '1, 1'b1);
      // row 1: diagonal goes in before column 3
      send_item(1'b0, 1'b0, COL_W'(0), '0, 1'b0);
      send_item(1'b0, 1'b0, COL_W'(3), random_value(), 1'b1);
      // row 2: diagonal goes at the end
      send_item(1'b0, 1'b0, COL_W'(0), random_value(), 1'b0);
      send_item(1'b0, 1'b0, COL_W'(1), random_value(), 1'b1);
      // row 3: empty row yields only the diagonal
      send_item(1'b0, 1'b1, '1, '1, 1'b1);
      // row 4: widest column
      send_item(1'b0, 1'b0, '1, 64'h5555_5555_5555_5555, 1'b1);
      // row 5: a marker ends a buffered row even without row_end
      send_item(1'b0, 1'b0, COL_W'(2), random_value(), 1'b0);
      send_item(1'b0, 1'b1, COL_W'(0), random_value(), 1'b0);
      // row 6: at the column count, empty, nothing comes out
      send_item(1'b0, 1'b1, COL_W'(0), '0, 1'b0);
      // row 7: beyond the column count, no diagonal
      send_item(1'b0, 1'b0, COL_W'(7), random_value(), 1'b0);
      send_item(1'b0, 1'b0, COL_W'(1), random_value(), 1'b1);
      // row 8 is cut short by a restart that opens row 0
      send_item(1'b0, 1'b0, COL_W'(8), random_value(), 1'b0);
      send_item(1'b0, 1'b0, COL_W'(3), random_value(), 1'b0);
      send_item(1'b1, 1'b0, COL_W'(0), 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      // row 1 from a marker with row_end set
      send_item(1'b0, 1'b1, COL_W'(0), '0, 1'b1);
      // row 2: diagonal after a larger column, no insertion
      send_item(1'b0, 1'b0, COL_W'(5), random_value(), 1'b0);
      send_item(1'b0, 1'b0, COL_W'(2), random_value(), 1'b1);

      // Random rows, sender idles lightly and receiver heavily
      send_random_rows(100);

      // Widest column count, idling swapped
      write_column_count('1);
      send_idle_pct = 83;
      recv_idle_pct = 36;
      send_random_rows(45);
      drain_results();
      send_random_rows(45);

      // Column count of one, then three, no idling
      write_column_count(COL_W'(1));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_rows(50);
      write_column_count(COL_W'(3));
      send_random_rows(40);

      drain_results();
      if (mismatch_count == 0 && results_awaited == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
